[hdl/gaussian_5x5_smoothing_top_macros.svh]
// assertion macros for the gaussian 5x5 smoothing block
`ifndef GAUSSIAN_5X5_SMOOTHING_TOP_MACROS_SVH
`define GAUSSIAN_5X5_SMOOTHING_TOP_MACROS_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define GS5_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GS5_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/gs5_pkg.sv]
// shared types and constants of the gaussian 5x5 smoothing block
`default_nettype none

package gs5_pkg;

	localparam int PORT_PIX_W     = 16;
	localparam int LEN_REG_W      = 12;
	localparam int CNT_REG_W      = 16;
	localparam int ROW_W          = CNT_REG_W + 1;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;

	localparam int DEF_MAX_LINE   = 2048;
	localparam int DEF_PIXEL_BITS = 16;
	localparam int LEN_RESET      = 640;
	localparam int CNT_RESET      = 480;

	localparam int LANES          = 4;
	localparam int LANE_W         = 2;
	localparam int WIN            = 5;

	localparam int KERNEL_SUM     = 273;
	localparam int ROUND_BIAS     = 136;
	localparam int KW_4           = 4;
	localparam int KW_7           = 7;
	localparam int KW_16          = 16;
	localparam int KW_26          = 26;
	localparam int KW_41          = 41;

	localparam int OUT_DEPTH      = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_LENGTH = 2'd0,
		REG_LINE_COUNT  = 2'd1
	} gs5_reg_t;

	typedef struct packed {
		logic emit;
		logic inner;
		logic last;
	} gs5_tag_t;

endpackage

`default_nettype wire

[hdl/gs5_feed_if.sv]
// pixel input channel
`default_nettype none

interface gs5_feed_if import gs5_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	logic [PORT_PIX_W-1:0] pixel_in;

	modport source (output valid, output req_type, output pixel_in, input ready);
	modport sink (input valid, input req_type, input pixel_in, output ready);
endinterface

`default_nettype wire

[hdl/gs5_result_if.sv]
// pixel result channel
`default_nettype none

interface gs5_result_if import gs5_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [PORT_PIX_W-1:0] pixel_out;
	logic                  frame_last;

	modport source (output valid, output pixel_out, output frame_last, input ready);
	modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

[hdl/gs5_cfg_if.sv]
// configuration write channel
`default_nettype none

interface gs5_cfg_if import gs5_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/gaussian_5x5_smoothing_top.sv]
// top level of the gaussian 5x5 smoothing block
// Takes one pixel per clock in raster order and returns each pixel smoothed by the
// 273-weight 5x5 kernel (pixels within two of an edge pass through), two lines plus
// two pixels behind the input; after the last pixel of a frame, filler transfers
// flush the tail. Sustained rate is one pixel per cycle while feed.ready is high:
// every pixel costs one read of all four line lanes and one lane write at the same
// column of a single line memory. A result passes the line memory read, the window,
// the group sums and the kernel stages into a 16-entry result queue; feed.ready
// drops only while 16 results are outstanding.
// The line memory has no clearing pass and needs no start-up time. Configuration
// is always accepted (cfg.ready is always high) and belongs between frames.
`default_nettype none
`include "gaussian_5x5_smoothing_top_macros.svh"

module gaussian_5x5_smoothing_top import gs5_pkg::*; #(
	parameter int MAX_LINE   = DEF_MAX_LINE,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	gs5_cfg_if.sink         cfg,
	gs5_feed_if.sink        feed,
	gs5_result_if.source    result
);

	localparam int COL_W  = $clog2(MAX_LINE);
	localparam int EL_W   = $clog2(MAX_LINE + 1);
	localparam int XW     = EL_W + 1;
	localparam int LEAD_W = $clog2(2 * MAX_LINE + 3);
	localparam int PEND_W = $clog2(OUT_DEPTH + 1);
	localparam int FIFO_W = PORT_PIX_W + 1;
	localparam int G2     = PIXEL_BITS + 2;
	localparam int G3     = PIXEL_BITS + 3;
	localparam int LenResetEff = (MAX_LINE < LEN_RESET) ? MAX_LINE : LEN_RESET;

	logic [EL_W-1:0]      len_q;
	logic [CNT_REG_W-1:0] cnt_q;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     ocol_q;
	logic [CNT_REG_W-1:0] orow_q;
	logic [LEAD_W-1:0]    lead_q;
	logic [PEND_W-1:0]    pend_q;

	logic [LEN_REG_W-1:0] len_wr;
	logic [EL_W-1:0]      len_new;
	logic [CNT_REG_W-1:0] cnt_new;

	logic                  acc;
	logic                  wrap0;
	logic [COL_W-1:0]      col_c;
	logic [ROW_W-1:0]      row_c;
	logic                  frame_in;
	logic                  step;
	logic                  mem_we;
	logic [PIXEL_BITS-1:0] pix0;
	logic [XW-1:0]         len_x;
	logic [XW-1:0]         col_inc;
	logic                  col_end;
	logic [XW-1:0]         ocol_x;
	logic                  ocol_end;
	logic [LEAD_W-1:0]     thr;
	logic                  out_en;
	logic                  inner;
	logic                  last;
	logic                  pend_dec;

	logic                             v_s1;
	logic [LANE_W-1:0]                lane_s1;
	logic [PIXEL_BITS-1:0]            pix_s1;
	gs5_tag_t                         tag_s1;
	logic [LANES-1:0][PIXEL_BITS-1:0] rd_s1;

	logic                  valid_s3;
	gs5_tag_t              tag_s3;
	logic [G2-1:0]         g1_s3;
	logic [G3-1:0]         g4_s3;
	logic [G2-1:0]         g7_s3;
	logic [G2-1:0]         g16_s3;
	logic [G2-1:0]         g26_s3;
	logic [PIXEL_BITS-1:0] center_s3;

	logic              push;
	logic [FIFO_W-1:0] push_data;
	logic [FIFO_W-1:0] fifo_dout;

	// config write decode, stored as effective sizes
	assign cfg.ready = 1'b1;
	assign len_wr    = cfg.data[LEN_REG_W-1:0];
	assign cnt_new   = (cfg.data[CNT_REG_W-1:0] == '0) ? CNT_REG_W'(1) : cfg.data[CNT_REG_W-1:0];

	always_comb begin
		if (len_wr == '0) begin
			len_new = EL_W'(1);
		end else if (32'(len_wr) > MAX_LINE) begin
			len_new = EL_W'(MAX_LINE);
		end else begin
			len_new = EL_W'(len_wr);
		end
	end

	// input position
	assign acc      = feed.valid & feed.ready;
	assign len_x    = XW'(len_q);
	assign wrap0    = XW'(col_q) >= len_x;
	assign col_c    = wrap0 ? '0 : col_q;
	assign row_c    = wrap0 ? row_q + ROW_W'(1) : row_q;
	assign frame_in = row_c >= ROW_W'(cnt_q);
	assign step     = acc & (~feed.req_type | frame_in);
	assign mem_we   = step & ~frame_in;
	assign pix0     = frame_in ? '0 : feed.pixel_in[PIXEL_BITS-1:0];
	assign col_inc  = XW'(col_c) + XW'(1);
	assign col_end  = col_inc >= len_x;

	// output position
	assign thr      = (LEAD_W'(len_q) << 1) + LEAD_W'(2);
	assign out_en   = lead_q >= thr;
	assign ocol_x   = XW'(ocol_q);
	assign ocol_end = ocol_x + XW'(1) >= len_x;
	assign inner    = (orow_q >= CNT_REG_W'(2))
	               && (ROW_W'(orow_q) + ROW_W'(2) < ROW_W'(cnt_q))
	               && (ocol_x >= XW'(2))
	               && (ocol_x + XW'(2) < len_x);
	assign last     = (orow_q > cnt_q - CNT_REG_W'(1))
	               || ((orow_q == cnt_q - CNT_REG_W'(1)) && ocol_end);

	assign pend_dec   = result.valid & result.ready;
	assign feed.ready = pend_q != PEND_W'(OUT_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= EL_W'(LenResetEff);
			cnt_q  <= CNT_REG_W'(CNT_RESET);
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			lead_q <= '0;
			pend_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_LINE_LENGTH: len_q <= len_new;
					REG_LINE_COUNT:  cnt_q <= cnt_new;
					default: ;
				endcase
			end
			if (step) begin
				if (out_en && last) begin
					col_q  <= '0;
					row_q  <= '0;
					ocol_q <= '0;
					orow_q <= '0;
					lead_q <= '0;
				end else begin
					if (col_end) begin
						col_q <= '0;
						row_q <= row_c + ROW_W'(1);
					end else begin
						col_q <= COL_W'(col_inc);
						row_q <= row_c;
					end
					if (out_en) begin
						if (ocol_end) begin
							ocol_q <= '0;
							orow_q <= orow_q + CNT_REG_W'(1);
						end else begin
							ocol_q <= ocol_q + COL_W'(1);
						end
					end else begin
						lead_q <= lead_q + LEAD_W'(1);
					end
				end
			end else if (acc && wrap0) begin
				col_q <= '0;
				row_q <= row_c;
			end
			pend_q <= pend_q + PEND_W'(step & out_en) - PEND_W'(pend_dec);
			v_s1   <= step;
		end
	end

	always_ff @(posedge clk) begin
		lane_s1      <= row_c[LANE_W-1:0];
		pix_s1       <= pix0;
		tag_s1.emit  <= out_en;
		tag_s1.inner <= inner;
		tag_s1.last  <= last;
	end

	gs5_line_mem #(
		.DEPTH (MAX_LINE),
		.PIX_W (PIXEL_BITS)
	) u_line_mem (
		.clk   (clk),
		.en    (step),
		.addr  (col_c),
		.we    (mem_we),
		.lane  (row_c[LANE_W-1:0]),
		.wdata (pix0),
		.rdata (rd_s1)
	);

	gs5_window #(
		.PIX_W (PIXEL_BITS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (v_s1),
		.lane      (lane_s1),
		.pix       (pix_s1),
		.col_data  (rd_s1),
		.tag_i     (tag_s1),
		.valid_s3  (valid_s3),
		.tag_s3    (tag_s3),
		.g1_s3     (g1_s3),
		.g4_s3     (g4_s3),
		.g7_s3     (g7_s3),
		.g16_s3    (g16_s3),
		.g26_s3    (g26_s3),
		.center_s3 (center_s3)
	);

	gs5_kernel #(
		.PIX_W (PIXEL_BITS)
	) u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.tag_s3    (tag_s3),
		.g1_s3     (g1_s3),
		.g4_s3     (g4_s3),
		.g7_s3     (g7_s3),
		.g16_s3    (g16_s3),
		.g26_s3    (g26_s3),
		.center_s3 (center_s3),
		.push      (push),
		.push_data (push_data)
	);

	gs5_out_fifo #(
		.DEPTH (OUT_DEPTH),
		.W     (FIFO_W)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (push_data),
		.pop_valid (result.valid),
		.pop_ready (result.ready),
		.dout      (fifo_dout)
	);

	assign result.pixel_out  = fifo_dout[PORT_PIX_W-1:0];
	assign result.frame_last = fifo_dout[PORT_PIX_W];

	`GS5_ASSERT_IMP(a_pend_bound, 1'b1, pend_q <= PEND_W'(OUT_DEPTH), "result credit overrun")
	`GS5_ASSERT_IMP(a_out_credit, result.valid, pend_q != '0, "result without credit")
	`GS5_ASSERT_IMP(a_wr_in_line, mem_we, XW'(col_c) < len_x, "line write beyond line length")
	`GS5_ASSERT_NXT(a_frame_restart, step && out_en && last,
		row_q == '0 && lead_q == '0 && orow_q == '0, "frame counters not cleared")

endmodule

`default_nettype wire

[hdl/gs5_line_mem.sv]
// four-line store, one word per column, lane write, read-first
`default_nettype none

module gs5_line_mem import gs5_pkg::*; #(
	parameter int DEPTH = DEF_MAX_LINE,
	parameter int PIX_W = DEF_PIXEL_BITS,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [AW-1:0]               addr,
	input  logic                        we,
	input  logic [LANE_W-1:0]           lane,
	input  logic [PIX_W-1:0]            wdata,
	output logic [LANES-1:0][PIX_W-1:0] rdata
);

	logic [LANES-1:0][PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr][lane] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

[hdl/gs5_window.sv]
// 5x5 window registers and coefficient group sums
`default_nettype none

module gs5_window import gs5_pkg::*; #(
	parameter int PIX_W = DEF_PIXEL_BITS,
	localparam int G2   = PIX_W + 2,
	localparam int G3   = PIX_W + 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        shift,
	input  logic [LANE_W-1:0]           lane,
	input  logic [PIX_W-1:0]            pix,
	input  logic [LANES-1:0][PIX_W-1:0] col_data,
	input  gs5_tag_t                    tag_i,
	output logic                        valid_s3,
	output gs5_tag_t                    tag_s3,
	output logic [G2-1:0]               g1_s3,
	output logic [G3-1:0]               g4_s3,
	output logic [G2-1:0]               g7_s3,
	output logic [G2-1:0]               g16_s3,
	output logic [G2-1:0]               g26_s3,
	output logic [PIX_W-1:0]            center_s3
);

	logic [PIX_W-1:0] win_q [WIN][WIN];
	logic             valid_s2;
	gs5_tag_t         tag_s2;
	logic [G2-1:0]    g1;
	logic [G3-1:0]    g4;
	logic [G2-1:0]    g7;
	logic [G2-1:0]    g16;
	logic [G2-1:0]    g26;

	// shift left, new column from the line store, newest pixel bottom right
	always_ff @(posedge clk) begin
		if (shift) begin
			for (int k = 0; k < WIN; k++) begin
				for (int j = 0; j < WIN - 1; j++) begin
					win_q[k][j] <= win_q[k][j+1];
				end
			end
			for (int k = 0; k < LANES; k++) begin
				win_q[k][WIN-1] <= col_data[lane + LANE_W'(k)];
			end
			win_q[WIN-1][WIN-1] <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= shift & tag_i.emit;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		g1  = G2'(win_q[0][0]) + G2'(win_q[0][4]) + G2'(win_q[4][0]) + G2'(win_q[4][4]);
		g4  = G3'(win_q[0][1]) + G3'(win_q[0][3]) + G3'(win_q[1][0]) + G3'(win_q[1][4])
		    + G3'(win_q[3][0]) + G3'(win_q[3][4]) + G3'(win_q[4][1]) + G3'(win_q[4][3]);
		g7  = G2'(win_q[0][2]) + G2'(win_q[2][0]) + G2'(win_q[2][4]) + G2'(win_q[4][2]);
		g16 = G2'(win_q[1][1]) + G2'(win_q[1][3]) + G2'(win_q[3][1]) + G2'(win_q[3][3]);
		g26 = G2'(win_q[1][2]) + G2'(win_q[2][1]) + G2'(win_q[2][3]) + G2'(win_q[3][2]);
	end

	always_ff @(posedge clk) begin
		tag_s2    <= tag_i;
		tag_s3    <= tag_s2;
		g1_s3     <= g1;
		g4_s3     <= g4;
		g7_s3     <= g7;
		g16_s3    <= g16;
		g26_s3    <= g26;
		center_s3 <= win_q[2][2];
	end

endmodule

`default_nettype wire

[hdl/gs5_kernel.sv]
// weighted kernel sum and rounded division by 273
`default_nettype none

module gs5_kernel import gs5_pkg::*; #(
	parameter int PIX_W  = DEF_PIXEL_BITS,
	localparam int G2    = PIX_W + 2,
	localparam int G3    = PIX_W + 3,
	localparam int OUT_W = PORT_PIX_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s3,
	input  gs5_tag_t         tag_s3,
	input  logic [G2-1:0]    g1_s3,
	input  logic [G3-1:0]    g4_s3,
	input  logic [G2-1:0]    g7_s3,
	input  logic [G2-1:0]    g16_s3,
	input  logic [G2-1:0]    g26_s3,
	input  logic [PIX_W-1:0] center_s3,
	output logic             push,
	output logic [OUT_W-1:0] push_data
);

	localparam int SUM_W  = PIX_W + 9;
	localparam int M_W    = PIX_W + 10;
	localparam int SHIFT  = PIX_W + 18;
	localparam int PROD_W = SUM_W + M_W;
	localparam longint unsigned RecipFull =
		((longint'(1) << SHIFT) + longint'(KERNEL_SUM - 1)) / longint'(KERNEL_SUM);
	localparam logic [M_W-1:0] RECIP = M_W'(RecipFull);

	logic              valid_s4;
	logic              valid_s5;
	logic              valid_s6;
	gs5_tag_t          tag_s4;
	gs5_tag_t          tag_s5;
	gs5_tag_t          tag_s6;
	logic [PIX_W-1:0]  center_s4;
	logic [PIX_W-1:0]  center_s5;
	logic [PIX_W-1:0]  center_s6;
	logic [SUM_W-1:0]  pa_s4;
	logic [SUM_W-1:0]  pb_s4;
	logic [SUM_W-1:0]  x_s5;
	logic [PROD_W-1:0] prod_s6;
	logic [PIX_W-1:0]  quot;
	logic [PIX_W-1:0]  val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		tag_s4    <= tag_s3;
		tag_s5    <= tag_s4;
		tag_s6    <= tag_s5;
		center_s4 <= center_s3;
		center_s5 <= center_s4;
		center_s6 <= center_s5;
		pa_s4     <= SUM_W'(g1_s3) + SUM_W'(g4_s3) * SUM_W'(KW_4)
		           + SUM_W'(g16_s3) * SUM_W'(KW_16) + SUM_W'(ROUND_BIAS);
		pb_s4     <= SUM_W'(g7_s3) * SUM_W'(KW_7) + SUM_W'(g26_s3) * SUM_W'(KW_26)
		           + SUM_W'(center_s3) * SUM_W'(KW_41);
		x_s5      <= pa_s4 + pb_s4;
		prod_s6   <= PROD_W'(x_s5) * PROD_W'(RECIP);
	end

	assign quot      = prod_s6[SHIFT +: PIX_W];
	assign val       = tag_s6.inner ? quot : center_s6;
	assign push      = valid_s6;
	assign push_data = {tag_s6.last, PORT_PIX_W'(val)};

endmodule

`default_nettype wire

[hdl/gs5_out_fifo.sv]
// result queue between the pipeline and the result channel
`default_nettype none

module gs5_out_fifo import gs5_pkg::*; #(
	parameter int DEPTH = OUT_DEPTH,
	parameter int W     = PORT_PIX_W + 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] dout
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign pop       = pop_valid & pop_ready;
	assign pop_valid = count_q != '0;
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

[tb/sv/gaussian_5x5_smoothing_top_test.sv]
// self-checking testbench for the 5x5 gaussian smoothing top level with a scoreboard class
module gaussian_5x5_smoothing_top_test import gs5_pkg::*; ;

	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_FILLER = 1'b1;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 2'd3;
	localparam int BULK_TARGET    = 1050;
	localparam int SETTLE_CYCLES  = 30;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 100;

	typedef enum {TEX_MIXED, TEX_BRIGHT} texture_t;
	typedef enum {DRAIN_FREE, DRAIN_RANDOM, DRAIN_CHOPPY, DRAIN_LONG} drain_mode_t;

	class smoothed_pixel_board;
		typedef struct packed {
			logic [PORT_PIX_W-1:0] pix;
			logic                  last;
		} due_pixel_t;

		logic [LEN_REG_W-1:0]  len_reg;
		logic [CNT_REG_W-1:0]  cnt_reg;
		logic [PORT_PIX_W-1:0] lanes [LANES*DEF_MAX_LINE];
		logic [PORT_PIX_W-1:0] win [WIN][WIN];
		int unsigned           taps [WIN][WIN];
		int unsigned           col;
		int unsigned           row;
		int unsigned           out_pos;
		due_pixel_t            due_pixels [$];

		function new();
			taps = '{'{1, KW_4, KW_7, KW_4, 1},
				'{KW_4, KW_16, KW_26, KW_16, KW_4},
				'{KW_7, KW_26, KW_41, KW_26, KW_7},
				'{KW_4, KW_16, KW_26, KW_16, KW_4},
				'{1, KW_4, KW_7, KW_4, 1}};
			len_reg = LEN_REG_W'(LEN_RESET);
			cnt_reg = CNT_REG_W'(CNT_RESET);
			foreach (lanes[i]) lanes[i] = '0;
			foreach (win[k, j]) win[k][j] = '0;
			col = 0;
			row = 0;
			out_pos = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_LINE_LENGTH) begin
				len_reg = value[LEN_REG_W-1:0];
			end else if (idx == REG_LINE_COUNT) begin
				cnt_reg = value[CNT_REG_W-1:0];
			end
		endfunction

		function int frame_width();
			if (len_reg == 0) return 1;
			if (len_reg > DEF_MAX_LINE) return DEF_MAX_LINE;
			return int'(len_reg);
		endfunction

		function int frame_height();
			return (cnt_reg == 0) ? 1 : int'(cnt_reg);
		endfunction

		function int pending();
			return due_pixels.size();
		endfunction

		function void take_pixel(logic kind, logic [PORT_PIX_W-1:0] value);
			int unsigned len;
			int unsigned cnt;
			int unsigned orow;
			int unsigned ocol;
			int unsigned sum;
			logic filler;
			logic flushing;
			logic [PORT_PIX_W-1:0] pix;
			longint unsigned idx;
			longint unsigned npix;
			due_pixel_t due;
			len = frame_width();
			cnt = frame_height();
			filler = (kind == KIND_FILLER);
			pix = value;
			flushing = (row >= cnt);
			if (col >= len) begin
				col = 0;
				row++;
				flushing = (row >= cnt);
			end
			if (filler && !flushing) return;
			// past the last line every item only pushes the tail out
			if (flushing) begin
				filler = 1'b1;
				pix = '0;
			end
			for (int k = 0; k < WIN; k++)
				for (int j = 0; j < WIN - 1; j++)
					win[k][j] = win[k][j+1];
			for (int k = 0; k < LANES; k++)
				win[k][WIN-1] = lanes[((row + k) % LANES) * DEF_MAX_LINE + col];
			win[WIN-1][WIN-1] = pix;
			if (!filler) lanes[(row % LANES) * DEF_MAX_LINE + col] = pix;
			idx = longint'(row) * len + col;
			col++;
			if (col >= len) begin
				col = 0;
				row++;
			end
			if (idx < 2 * longint'(len) + 2) return;
			orow = out_pos / len;
			ocol = out_pos % len;
			npix = longint'(len) * longint'(cnt);
			if (orow >= 2 && orow + 2 < cnt && ocol >= 2 && ocol + 2 < len) begin
				sum = 0;
				for (int k = 0; k < WIN; k++)
					for (int j = 0; j < WIN; j++)
						sum += taps[k][j] * win[k][j];
				due.pix = PORT_PIX_W'((sum + ROUND_BIAS) / KERNEL_SUM);
			end else begin
				due.pix = win[2][2];
			end
			if (longint'(out_pos) + 1 >= npix) begin
				due.last = 1'b1;
				col = 0;
				row = 0;
				out_pos = 0;
			end else begin
				due.last = 1'b0;
				out_pos = (out_pos + 1) & 32'h07FF_FFFF;
			end
			due_pixels = {due_pixels, due};
		endfunction

		function string check_pixel(logic [PORT_PIX_W-1:0] pix, logic last);
			due_pixel_t due;
			string verdict;
			if (due_pixels.size() == 0)
				return $sformatf("unexpected result pixel_out=%h frame_last=%b", pix, last);
			due = due_pixels.pop_front();
			verdict = "";
			if (pix !== due.pix)
				verdict = $sformatf("pixel_out %h, predicted %h", pix, due.pix);
			if (last !== due.last)
				verdict = {verdict, (verdict == "") ? "" : "; ",
					$sformatf("frame_last %b, predicted %b", last, due.last)};
			return verdict;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	gs5_cfg_if    cfg_ch ();
	gs5_feed_if   feed_ch ();
	gs5_result_if res_ch ();

	gaussian_5x5_smoothing_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.feed   (feed_ch),
		.result (res_ch)
	);

	smoothed_pixel_board board = new();

	int mismatches = 0;
	int in_transfers = 0;
	int results_seen = 0;
	int frames_run = 0;
	int sizes_run = 0;
	int bulk_items = 0;
	int widest = 0;
	int tallest = 0;
	int burst_left = 0;
	int quiet = 0;
	string verdict;

	drain_mode_t drain_mode = DRAIN_FREE;
	int mode_left = 0;
	int chop_phase = 0;
	int hold_left = 0;
	logic take;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("mismatch at result %0d: %s", results_seen, what);
	endtask

	// transfers are sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) board.set_reg(cfg_ch.index, cfg_ch.data);
			if (feed_ch.valid && feed_ch.ready) begin
				board.take_pixel(feed_ch.req_type, feed_ch.pixel_in);
				in_transfers++;
			end
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				verdict = board.check_pixel(res_ch.pixel_out, res_ch.frame_last);
				if (verdict != "") report(verdict);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (feed_ch.valid && feed_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
		end
	end

	initial begin
		while (quiet < WATCHDOG_LIMIT) @(posedge clk);
		$display("no transfer for %0d cycles, %0d results outstanding", quiet, board.pending());
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (mode_left == 0) begin
			drain_mode = drain_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(64, 400);
		end
		mode_left--;
		case (drain_mode)
			DRAIN_FREE: take = 1'b1;
			DRAIN_RANDOM: take = ($urandom_range(0, 2) != 0);
			DRAIN_CHOPPY: begin
				take = ((chop_phase % 7) > 2);
				chop_phase++;
			end
			default: begin
				if (hold_left > 0) begin
					take = 1'b0;
					hold_left--;
				end else begin
					take = 1'b1;
					if ($urandom_range(0, 49) == 0) hold_left = $urandom_range(10, 40);
				end
			end
		endcase
		res_ch.ready <= take;
	end

	function automatic logic [PORT_PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return PORT_PIX_W'($urandom_range(0, 15));
			3: return PORT_PIX_W'(16'hFFFF - $urandom_range(0, 15));
			default: return PORT_PIX_W'($urandom);
		endcase
	endfunction

	function automatic int random_length();
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(1, 4);
			2: return $urandom_range(25, 80);
			default: return $urandom_range(5, 24);
		endcase
	endfunction

	function automatic int random_count();
		case ($urandom_range(0, 5))
			0: return $urandom_range(1, 4);
			default: return $urandom_range(5, 12);
		endcase
	endfunction

	// sender works in bursts with random gaps between them
	task automatic send_item(input logic kind, input logic [PORT_PIX_W-1:0] value);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 24);
			case ($urandom_range(0, 5))
				0, 1, 2: gap = 0;
				3, 4: gap = $urandom_range(1, 4);
				default: gap = $urandom_range(5, 20);
			endcase
			if (gap > 0) begin
				feed_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		feed_ch.valid <= 1'b1;
		feed_ch.req_type <= kind;
		feed_ch.pixel_in <= value;
		@(posedge clk);
		while (!feed_ch.ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic settle();
		feed_ch.valid <= 1'b0;
		burst_left = 0;
		while (board.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic resize(input logic [CFG_DATA_W-1:0] len_word,
			input logic [CFG_DATA_W-1:0] cnt_word);
		settle();
		write_reg(REG_LINE_LENGTH, len_word);
		write_reg(REG_LINE_COUNT, cnt_word);
		if ($urandom_range(0, 3) == 0)
			write_reg(($urandom_range(0, 1) != 0) ? IDX_SPARE_HI : IDX_SPARE_LO,
				CFG_DATA_W'($urandom));
		cfg_ch.valid <= 1'b0;
		sizes_run++;
	endtask

	// one frame: pixels with stray fillers, then the flush tail with stray pixels
	task automatic run_frame(input texture_t look);
		int w;
		int h;
		w = board.frame_width();
		h = board.frame_height();
		for (int k = 0; k < w * h; k++) begin
			if ($urandom_range(0, 19) == 0) send_item(KIND_FILLER, PORT_PIX_W'($urandom));
			send_item(KIND_PIXEL, (look == TEX_BRIGHT) ? {PORT_PIX_W{1'b1}} : pick_pixel());
		end
		for (int k = 0; k < 2 * w + 2; k++)
			send_item(($urandom_range(0, 9) == 0) ? KIND_PIXEL : KIND_FILLER,
				PORT_PIX_W'($urandom));
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_item(KIND_FILLER, PORT_PIX_W'($urandom));
		frames_run++;
		bulk_items += w * h + 2 * w + 2;
		if (w > widest) widest = w;
		if (h > tallest) tallest = h;
	endtask

	task automatic probe_frames();
		logic [PORT_PIX_W-1:0] corner [9];
		corner = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
			16'hFFFE, 16'hAAAA, 16'h5555, 16'h0000};
		resize(16'd3, 16'd3);
		for (int k = 0; k < 9; k++) begin
			if (k == 4) send_item(KIND_FILLER, 16'hFFFF);
			send_item(KIND_PIXEL, corner[k]);
		end
		for (int k = 0; k < 8; k++)
			send_item((k == 3) ? KIND_PIXEL : KIND_FILLER, PORT_PIX_W'($urandom));
		send_item(KIND_FILLER, 16'h0000);
		// zero sizes fall back to a single pixel frame
		resize(16'hF000, 16'h0000);
		send_item(KIND_PIXEL, 16'hFFFF);
		repeat (4) send_item(KIND_FILLER, PORT_PIX_W'($urandom));
		frames_run += 2;
	endtask

	initial begin
		arst_n = 1'b0;
		feed_ch.valid = 1'b0;
		feed_ch.req_type = KIND_PIXEL;
		feed_ch.pixel_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_LINE_LENGTH;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		probe_frames();

		bulk_items = 0;
		while (bulk_items < BULK_TARGET) begin
			resize({4'($urandom), 12'(random_length())}, 16'(random_count()));
			repeat ($urandom_range(1, 3))
				if (bulk_items < BULK_TARGET)
					run_frame(($urandom_range(0, 7) == 0) ? TEX_BRIGHT : TEX_MIXED);
		end

		// a tall frame one pixel wide
		resize(16'h0001, 16'd120);
		run_frame(TEX_MIXED);

		feed_ch.valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("ran %0d frames over %0d size settings, up to %0d x %0d pixels",
			frames_run, sizes_run, widest, tallest);
		$display("%0d input transfers, %0d results checked, %0d mismatches",
			in_transfers, results_seen, mismatches);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
